>>> design/hpd_pkg.sv
// hpd_pkg: shared types, codes and reset values of the h-bridge position drive controller
// no dependencies; imported by hpd_cfg, hpd_step and the top level
`timescale 1ns / 1ps
`default_nettype none

package hpd_pkg;

  typedef enum logic [1:0] {
    MODE_STOP  = 2'd0,
    MODE_OPEN  = 2'd1,
    MODE_CLOSE = 2'd2,
    MODE_GOTO  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PWM_DUTY      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARRIVE_BAND   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REV_PAUSE_MS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_INVERT  = 3'd3;

  localparam logic [7:0]  PWM_DUTY_RST     = 8'd128;
  localparam logic [9:0]  ARRIVE_BAND_RST  = 10'd10;
  localparam logic [15:0] REV_PAUSE_MS_RST = 16'd1000;

  typedef struct packed {
    logic [7:0]  pwm_duty;
    logic [9:0]  arrive_band;
    logic [15:0] reverse_pause_ms;
    logic        motor_invert;
  } cfg_t;

  typedef struct packed {
    logic [7:0] duty1;
    logic [7:0] duty2;
    logic       low1;
    logic       low2;
  } levels_t;

  localparam levels_t LEVELS_OFF = '{duty1: 8'd0, duty2: 8'd0, low1: 1'b0, low2: 1'b0};

  typedef struct packed {
    logic               cmd_valid;
    logic [1:0]         cmd;
    logic signed [31:0] position;
    logic signed [31:0] target_position;
    logic [31:0]        now_ms;
    logic               at_closed_stop;
    logic               at_open_stop;
    logic               protect_tripped;
  } item_t;

  typedef struct packed {
    mode_t       req_mode;
    mode_t       run_mode;
    dir_t        dir;
    logic        pause;
    logic [31:0] pause_start;
    levels_t     levels;
  } state_t;

  typedef struct packed {
    logic [7:0] leg_a_duty;
    logic [7:0] leg_b_duty;
    logic       leg_a_low_on;
    logic       leg_b_low_on;
    logic [1:0] count_dir_write;
    logic       protection_reset;
    logic       save_position;
    logic       stop_event;
    logic [1:0] stop_event_mode;
    logic       protect_flag_clear;
    logic [1:0] drive_mode;
    logic       reverse_pausing;
  } result_t;

endpackage

`default_nettype wire

>>> design/hpd_cfg.sv
// hpd_cfg: configuration register file of the drive controller
// depends on hpd_pkg for the register indexes and reset values
`timescale 1ns / 1ps
`default_nettype none

module hpd_cfg
  import hpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pwm_duty         <= PWM_DUTY_RST;
      cfg.arrive_band      <= ARRIVE_BAND_RST;
      cfg.reverse_pause_ms <= REV_PAUSE_MS_RST;
      cfg.motor_invert     <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_PWM_DUTY:     cfg.pwm_duty         <= cfg_data[7:0];
        CFG_ARRIVE_BAND:  cfg.arrive_band      <= cfg_data[9:0];
        CFG_REV_PAUSE_MS: cfg.reverse_pause_ms <= cfg_data[15:0];
        CFG_MOTOR_INVERT: cfg.motor_invert     <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/hpd_step.sv
// hpd_step: one control tick, next state and result from current state and input
// depends on hpd_pkg for modes, directions, state and result types
`timescale 1ns / 1ps
`default_nettype none

module hpd_step
  import hpd_pkg::*;
(
  input  cfg_t    cfg,
  input  item_t   item,
  input  state_t  cur,
  output state_t  nxt,
  output result_t res
);

  state_t       s;
  dir_t         cdir;
  logic         prst;
  logic         save;
  logic         sev;
  mode_t        sevm;
  logic         clr;
  logic         done;
  logic         pause_go;
  logic [31:0]  elapsed;
  logic [32:0]  pos_x;
  logic [32:0]  tgt_x;
  logic [32:0]  diff_pt;
  logic [32:0]  diff_tp;
  logic [32:0]  distance;
  logic         pos_gt;
  logic         pos_lt;
  logic         near;
  levels_t      lv_up;
  levels_t      lv_down;

  assign lv_up   = '{duty1: cfg.pwm_duty, duty2: 8'd0, low1: 1'b0, low2: 1'b1};
  assign lv_down = '{duty1: 8'd0, duty2: cfg.pwm_duty, low1: 1'b1, low2: 1'b0};

  assign elapsed  = item.now_ms - cur.pause_start;
  assign pos_x    = {item.position[31], item.position};
  assign tgt_x    = {item.target_position[31], item.target_position};
  assign diff_pt  = pos_x - tgt_x;
  assign diff_tp  = tgt_x - pos_x;
  assign pos_gt   = $signed(pos_x) > $signed(tgt_x);
  assign pos_lt   = $signed(pos_x) < $signed(tgt_x);
  assign distance = pos_gt ? diff_pt : diff_tp;
  assign near     = distance <= {23'd0, cfg.arrive_band};

  always_comb begin
    s        = cur;
    cdir     = DIR_NONE;
    prst     = 1'b0;
    save     = 1'b0;
    sev      = 1'b0;
    sevm     = MODE_STOP;
    clr      = 1'b0;
    done     = 1'b0;
    pause_go = 1'b0;

    if (item.cmd_valid) begin
      s.req_mode = mode_t'(item.cmd);
    end

    // reversal pause
    if (s.pause) begin
      s.levels = LEVELS_OFF;
      if (elapsed < {16'd0, cfg.reverse_pause_ms}) begin
        done = 1'b1;
      end else begin
        s.pause = 1'b0;
        prst    = 1'b1;
        unique case (s.req_mode)
          MODE_GOTO: begin
            if (s.dir == DIR_UP) begin
              cdir       = DIR_UP;
              s.levels   = lv_up;
              s.run_mode = MODE_GOTO;
            end else if (s.dir == DIR_DOWN) begin
              cdir       = DIR_DOWN;
              s.levels   = lv_down;
              s.run_mode = MODE_GOTO;
            end
          end
          MODE_OPEN:  cdir = DIR_UP;
          MODE_CLOSE: cdir = DIR_DOWN;
          MODE_STOP:  ;
        endcase
      end
    end

    if (!done) begin
      if (s.req_mode == MODE_GOTO) begin
        if (near) begin
          s.levels   = LEVELS_OFF;
          s.dir      = DIR_NONE;
          s.run_mode = MODE_STOP;
          s.req_mode = MODE_STOP;
          save       = 1'b1;
        end else if (pos_lt) begin
          if (s.dir != DIR_UP) begin
            if (s.dir == DIR_DOWN || s.run_mode == MODE_CLOSE) begin
              pause_go = 1'b1;
            end else begin
              prst       = 1'b1;
              cdir       = DIR_UP;
              s.levels   = lv_up;
              s.run_mode = MODE_GOTO;
            end
            s.dir = DIR_UP;
          end
        end else if (s.dir != DIR_DOWN) begin
          if (s.dir == DIR_UP || s.run_mode == MODE_OPEN) begin
            pause_go = 1'b1;
          end else begin
            prst       = 1'b1;
            cdir       = DIR_DOWN;
            s.levels   = lv_down;
            s.run_mode = MODE_GOTO;
          end
          s.dir = DIR_DOWN;
        end
      end else begin
        // end-stop lockouts
        if (s.req_mode == MODE_CLOSE && item.at_closed_stop) s.req_mode = MODE_STOP;
        if (s.req_mode == MODE_OPEN && item.at_open_stop) s.req_mode = MODE_STOP;

        if (s.req_mode == MODE_STOP) begin
          s.levels = LEVELS_OFF;
          s.dir    = DIR_NONE;
          if (s.run_mode != MODE_STOP) begin
            if (item.protect_tripped) begin
              sev  = 1'b1;
              sevm = s.run_mode;
              clr  = 1'b1;
            end else begin
              save = 1'b1;
            end
            s.run_mode = MODE_STOP;
          end
        end else if (s.req_mode != s.run_mode) begin
          if (s.run_mode != MODE_STOP) begin
            pause_go = 1'b1;
          end else begin
            if (s.req_mode == MODE_OPEN) begin
              cdir     = DIR_UP;
              s.levels = lv_up;
            end else begin
              cdir     = DIR_DOWN;
              s.levels = lv_down;
            end
            s.run_mode = s.req_mode;
          end
        end
      end
    end

    if (pause_go) begin
      s.pause       = 1'b1;
      s.pause_start = item.now_ms;
      clr           = 1'b1;
      s.levels      = LEVELS_OFF;
      s.run_mode    = MODE_STOP;
    end
  end

  assign nxt = s;

  always_comb begin
    if (cfg.motor_invert) begin
      res.leg_a_duty   = s.levels.duty2;
      res.leg_b_duty   = s.levels.duty1;
      res.leg_a_low_on = s.levels.low2;
      res.leg_b_low_on = s.levels.low1;
    end else begin
      res.leg_a_duty   = s.levels.duty1;
      res.leg_b_duty   = s.levels.duty2;
      res.leg_a_low_on = s.levels.low1;
      res.leg_b_low_on = s.levels.low2;
    end
    res.count_dir_write    = cdir;
    res.protection_reset   = prst;
    res.save_position      = save;
    res.stop_event         = sev;
    res.stop_event_mode    = sevm;
    res.protect_flag_clear = clr;
    res.drive_mode         = s.run_mode;
    res.reverse_pausing    = s.pause;
  end

endmodule

`default_nettype wire

>>> design/hbridge_position_drive_controller_unit.sv
// hbridge_position_drive_controller_unit: top level, input register, state, result register
// depends on hpd_pkg, hpd_cfg and hpd_step
//
//   channel  direction  handshake             payload
//   in       receive    in_valid / in_stall   cmd_valid .. protect_tripped
//   out      send       out_valid / out_stall leg_a_duty .. reverse_pausing
//   cfg      receive    cfg_write             cfg_index, cfg_data
//
// one transaction per cycle sustained while out_stall is low; input register, then result register
// the control step is one pass of shallow compare and mode logic between the two registers
// state advances when the input register moves into the result register
// a stalled result holds; the input register still takes one more transaction
// rst is synchronous and returns modes to stop, bridge off and registers to reset values
`timescale 1ns / 1ps
`default_nettype none

module hbridge_position_drive_controller_unit
  import hpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  cmd_valid,
  input  logic [1:0]            cmd,
  input  logic signed [31:0]    position,
  input  logic signed [31:0]    target_position,
  input  logic [31:0]           now_ms,
  input  logic                  at_closed_stop,
  input  logic                  at_open_stop,
  input  logic                  protect_tripped,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            leg_a_duty,
  output logic [7:0]            leg_b_duty,
  output logic                  leg_a_low_on,
  output logic                  leg_b_low_on,
  output logic [1:0]            count_dir_write,
  output logic                  protection_reset,
  output logic                  save_position,
  output logic                  stop_event,
  output logic [1:0]            stop_event_mode,
  output logic                  protect_flag_clear,
  output logic [1:0]            drive_mode,
  output logic                  reverse_pausing,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  item_t   item;
  logic    item_vld;
  state_t  state;
  state_t  state_next;
  result_t res_next;
  result_t res;
  logic    advance;
  logic    fire;
  logic    in_take;

  hpd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hpd_step u_step (
    .cfg  (cfg),
    .item (item),
    .cur  (state),
    .nxt  (state_next),
    .res  (res_next)
  );

  assign advance  = !out_valid || !out_stall;
  assign fire     = item_vld && advance;
  assign in_stall = item_vld && !advance;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (in_take) begin
      item_vld <= 1'b1;
    end else if (advance) begin
      item_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item <= '{cmd_valid: cmd_valid, cmd: cmd, position: position,
                target_position: target_position, now_ms: now_ms,
                at_closed_stop: at_closed_stop, at_open_stop: at_open_stop,
                protect_tripped: protect_tripped};
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.req_mode    <= MODE_STOP;
      state.run_mode    <= MODE_STOP;
      state.dir         <= DIR_NONE;
      state.pause       <= 1'b0;
      state.pause_start <= 32'd0;
      state.levels      <= LEVELS_OFF;
    end else if (fire) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

  assign leg_a_duty         = res.leg_a_duty;
  assign leg_b_duty         = res.leg_b_duty;
  assign leg_a_low_on       = res.leg_a_low_on;
  assign leg_b_low_on       = res.leg_b_low_on;
  assign count_dir_write    = res.count_dir_write;
  assign protection_reset   = res.protection_reset;
  assign save_position      = res.save_position;
  assign stop_event         = res.stop_event;
  assign stop_event_mode    = res.stop_event_mode;
  assign protect_flag_clear = res.protect_flag_clear;
  assign drive_mode         = res.drive_mode;
  assign reverse_pausing    = res.reverse_pausing;

  // no shoot-through on either leg
  a_no_shoot_a: assert property (@(posedge clk) disable iff (rst)
    out_valid && leg_a_low_on |-> leg_a_duty == 8'd0)
    else $error("leg a high and low side on together");

  a_no_shoot_b: assert property (@(posedge clk) disable iff (rst)
    out_valid && leg_b_low_on |-> leg_b_duty == 8'd0)
    else $error("leg b high and low side on together");

  a_pause_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && reverse_pausing |->
      leg_a_duty == 8'd0 && leg_b_duty == 8'd0 && !leg_a_low_on && !leg_b_low_on
      && drive_mode == MODE_STOP)
    else $error("bridge driven during reversal pause");

  a_stop_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && stop_event |-> protect_flag_clear && !save_position)
    else $error("protection stop without trip clear");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && item_vld)
    else $error("input stalled with result side free");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(state))
    else $error("control state moved without a transaction");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// tb_top: self-checking bench for hbridge_position_drive_controller_unit
// a per-tick predictor in a scoreboard class checks every result transaction
// depends on hpd_pkg and the design top level
`timescale 1ns / 1ps

module tb_top;
  import hpd_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int POS_MIN = 32'sh8000_0000;
  localparam int POS_MAX = 32'sh7fff_ffff;

  class drive_scoreboard;
    cfg_t        regs;
    mode_t       req_mode;
    mode_t       run_mode;
    dir_t        move_dir;
    bit          pausing;
    logic [31:0] pause_t0;
    levels_t     lv;
    dir_t        cdir;
    bit          prst, save, sev, clr;
    mode_t       sev_mode;
    result_t     expected_q[$];
    int          errors, ticks, checked, pauses, stop_events;

    function new();
      regs = '{pwm_duty: PWM_DUTY_RST, arrive_band: ARRIVE_BAND_RST,
               reverse_pause_ms: REV_PAUSE_MS_RST, motor_invert: 1'b0};
      req_mode = MODE_STOP;
      run_mode = MODE_STOP;
      move_dir = DIR_NONE;
      pausing = 1'b0;
      pause_t0 = '0;
      lv = LEVELS_OFF;
      errors = 0;
      ticks = 0;
      checked = 0;
      pauses = 0;
      stop_events = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PWM_DUTY:     regs.pwm_duty = data[7:0];
        CFG_ARRIVE_BAND:  regs.arrive_band = data[9:0];
        CFG_REV_PAUSE_MS: regs.reverse_pause_ms = data[15:0];
        CFG_MOTOR_INVERT: regs.motor_invert = data[0];
        default: ;
      endcase
    endfunction

    function void bridge_up();
      lv = '{duty1: regs.pwm_duty, duty2: 8'd0, low1: 1'b0, low2: 1'b1};
    endfunction

    function void bridge_down();
      lv = '{duty1: 8'd0, duty2: regs.pwm_duty, low1: 1'b1, low2: 1'b0};
    endfunction

    function void enter_pause(logic [31:0] now);
      pausing = 1'b1;
      pause_t0 = now;
      clr = 1'b1;
      lv = LEVELS_OFF;
      run_mode = MODE_STOP;
      pauses++;
    endfunction

    function void advance(item_t it);
      longint pos, tgt, distance, band;
      logic [31:0] elapsed;
      if (pausing) begin
        lv = LEVELS_OFF;
        elapsed = it.now_ms - pause_t0;
        if (elapsed < {16'd0, regs.reverse_pause_ms}) return;
        pausing = 1'b0;
        prst = 1'b1;
        if (req_mode == MODE_GOTO) begin
          if (move_dir == DIR_UP) begin
            cdir = DIR_UP;
            bridge_up();
            run_mode = MODE_GOTO;
          end else if (move_dir == DIR_DOWN) begin
            cdir = DIR_DOWN;
            bridge_down();
            run_mode = MODE_GOTO;
          end
        end else if (req_mode == MODE_OPEN) begin
          cdir = DIR_UP;
        end else if (req_mode == MODE_CLOSE) begin
          cdir = DIR_DOWN;
        end
      end

      if (req_mode == MODE_GOTO) begin
        pos = $signed(it.position);
        tgt = $signed(it.target_position);
        distance = (pos > tgt) ? pos - tgt : tgt - pos;
        band = regs.arrive_band;
        if (distance <= band) begin
          lv = LEVELS_OFF;
          move_dir = DIR_NONE;
          run_mode = MODE_STOP;
          req_mode = MODE_STOP;
          save = 1'b1;
          return;
        end
        if (pos < tgt) begin
          if (move_dir != DIR_UP) begin
            if (move_dir == DIR_DOWN || run_mode == MODE_CLOSE) begin
              enter_pause(it.now_ms);
              move_dir = DIR_UP;
              return;
            end
            prst = 1'b1;
            cdir = DIR_UP;
            bridge_up();
            move_dir = DIR_UP;
            run_mode = MODE_GOTO;
          end
        end else if (move_dir != DIR_DOWN) begin
          if (move_dir == DIR_UP || run_mode == MODE_OPEN) begin
            enter_pause(it.now_ms);
            move_dir = DIR_DOWN;
            return;
          end
          prst = 1'b1;
          cdir = DIR_DOWN;
          bridge_down();
          move_dir = DIR_DOWN;
          run_mode = MODE_GOTO;
        end
        return;
      end

      if (req_mode == MODE_CLOSE && it.at_closed_stop) req_mode = MODE_STOP;
      if (req_mode == MODE_OPEN && it.at_open_stop) req_mode = MODE_STOP;

      if (req_mode == MODE_STOP) begin
        lv = LEVELS_OFF;
        move_dir = DIR_NONE;
        if (run_mode != MODE_STOP) begin
          if (it.protect_tripped) begin
            sev = 1'b1;
            sev_mode = run_mode;
            clr = 1'b1;
            stop_events++;
          end else begin
            save = 1'b1;
          end
          run_mode = MODE_STOP;
        end
        return;
      end

      if (req_mode != run_mode) begin
        if (run_mode != MODE_STOP) begin
          enter_pause(it.now_ms);
          return;
        end
        if (req_mode == MODE_OPEN) begin
          cdir = DIR_UP;
          bridge_up();
        end else begin
          cdir = DIR_DOWN;
          bridge_down();
        end
        run_mode = req_mode;
      end
    endfunction

    function void note_tick(item_t it);
      result_t r;
      cdir = DIR_NONE;
      prst = 1'b0;
      save = 1'b0;
      sev = 1'b0;
      sev_mode = MODE_STOP;
      clr = 1'b0;
      if (it.cmd_valid) req_mode = mode_t'(it.cmd);
      advance(it);
      if (regs.motor_invert) begin
        r.leg_a_duty = lv.duty2;
        r.leg_b_duty = lv.duty1;
        r.leg_a_low_on = lv.low2;
        r.leg_b_low_on = lv.low1;
      end else begin
        r.leg_a_duty = lv.duty1;
        r.leg_b_duty = lv.duty2;
        r.leg_a_low_on = lv.low1;
        r.leg_b_low_on = lv.low2;
      end
      r.count_dir_write = cdir;
      r.protection_reset = prst;
      r.save_position = save;
      r.stop_event = sev;
      r.stop_event_mode = sev_mode;
      r.protect_flag_clear = clr;
      r.drive_mode = run_mode;
      r.reverse_pausing = pausing;
      expected_q.push_back(r);
      ticks++;
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: result transaction with nothing expected, actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      compare_field("leg_a_duty", want.leg_a_duty, got.leg_a_duty);
      compare_field("leg_b_duty", want.leg_b_duty, got.leg_b_duty);
      compare_field("leg_a_low_on", want.leg_a_low_on, got.leg_a_low_on);
      compare_field("leg_b_low_on", want.leg_b_low_on, got.leg_b_low_on);
      compare_field("count_dir_write", want.count_dir_write, got.count_dir_write);
      compare_field("protection_reset", want.protection_reset, got.protection_reset);
      compare_field("save_position", want.save_position, got.save_position);
      compare_field("stop_event", want.stop_event, got.stop_event);
      compare_field("stop_event_mode", want.stop_event_mode, got.stop_event_mode);
      compare_field("protect_flag_clear", want.protect_flag_clear, got.protect_flag_clear);
      compare_field("drive_mode", want.drive_mode, got.drive_mode);
      compare_field("reverse_pausing", want.reverse_pausing, got.reverse_pausing);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  cmd_valid = 1'b0;
  logic [1:0]            cmd = '0;
  logic signed [31:0]    position = '0;
  logic signed [31:0]    target_position = '0;
  logic [31:0]           now_ms = '0;
  logic                  at_closed_stop = 1'b0;
  logic                  at_open_stop = 1'b0;
  logic                  protect_tripped = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            leg_a_duty;
  logic [7:0]            leg_b_duty;
  logic                  leg_a_low_on;
  logic                  leg_b_low_on;
  logic [1:0]            count_dir_write;
  logic                  protection_reset;
  logic                  save_position;
  logic                  stop_event;
  logic [1:0]            stop_event_mode;
  logic                  protect_flag_clear;
  logic [1:0]            drive_mode;
  logic                  reverse_pausing;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  drive_scoreboard sb = new();
  bit              quiet = 1'b0;
  int              world_pos = 0;
  int              world_tgt = 0;
  logic [31:0]     world_ms = 32'd5000;

  hbridge_position_drive_controller_unit u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 15);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(result_t'({leg_a_duty, leg_b_duty, leg_a_low_on, leg_b_low_on,
                                 count_dir_write, protection_reset, save_position,
                                 stop_event, stop_event_mode, protect_flag_clear,
                                 drive_mode, reverse_pausing}));
  end

  // holds the tick until the block takes it; prediction runs at the accepting edge
  task automatic send_tick(item_t it);
    while (!quiet && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd_valid <= it.cmd_valid;
    cmd <= it.cmd;
    position <= it.position;
    target_position <= it.target_position;
    now_ms <= it.now_ms;
    at_closed_stop <= it.at_closed_stop;
    at_open_stop <= it.at_open_stop;
    protect_tripped <= it.protect_tripped;
    do @(posedge clk); while (in_stall);
    sb.note_tick(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic poke(bit cv, mode_t c, int pos, int tgt, logic [31:0] t,
                      bit cl, bit op, bit tr);
    item_t it;
    it.cmd_valid = cv;
    it.cmd = c;
    it.position = pos;
    it.target_position = tgt;
    it.now_ms = t;
    it.at_closed_stop = cl;
    it.at_open_stop = op;
    it.protect_tripped = tr;
    send_tick(it);
  endtask

  // upper data bits and a spare index get junk, the block must ignore both
  task automatic program_regs(logic [7:0] duty, logic [9:0] band, logic [15:0] pause_ms,
                              logic inv);
    logic [CFG_IDX_W-1:0]  idxs[5];
    logic [CFG_DATA_W-1:0] vals[5];
    drain();
    idxs = '{CFG_PWM_DUTY, CFG_ARRIVE_BAND, CFG_REV_PAUSE_MS, CFG_MOTOR_INVERT,
             CFG_MOTOR_INVERT + 3'd1 + 3'($urandom_range(3))};
    vals = '{{8'($urandom), duty}, {6'($urandom), band}, pause_ms,
             {15'($urandom), inv}, 16'($urandom)};
    for (int i = 0; i < 5; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.write_reg(idxs[i], vals[i]);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic directed_ticks();
    poke(1, MODE_STOP, 0, 0, 32'd100, 0, 0, 1);     // stop while idle, trip ignored
    poke(1, MODE_OPEN, 0, 0, 32'd110, 0, 0, 0);
    poke(0, MODE_GOTO, 0, 0, 32'd120, 0, 0, 0);     // cmd without cmd_valid
    poke(1, MODE_STOP, 0, 0, 32'd130, 0, 0, 1);     // protection stop while opening
    poke(1, MODE_CLOSE, 0, 0, 32'd140, 0, 0, 0);
    poke(1, MODE_STOP, 0, 0, 32'd150, 0, 0, 0);     // plain stop saves position
    poke(1, MODE_OPEN, 0, 0, 32'd160, 0, 1, 0);     // refused at open stop
    poke(1, MODE_CLOSE, 0, 0, 32'd170, 0, 0, 0);
    poke(0, MODE_STOP, 0, 0, 32'd180, 1, 0, 0);     // reaches closed stop
    poke(1, MODE_OPEN, 0, 0, 32'd200, 0, 0, 0);
    poke(1, MODE_CLOSE, 0, 0, 32'd210, 0, 0, 0);    // manual reversal
    poke(0, MODE_STOP, 0, 0, 32'd1209, 0, 0, 0);    // one ms short of the pause
    poke(0, MODE_STOP, 0, 0, 32'd1210, 0, 0, 0);
    poke(1, MODE_GOTO, POS_MIN, POS_MAX, 32'd1300, 0, 0, 0);
    poke(0, MODE_STOP, POS_MIN, POS_MAX, 32'd2300, 0, 0, 0);
    poke(1, MODE_GOTO, POS_MAX, POS_MIN, 32'd2400, 0, 0, 0);
    poke(0, MODE_STOP, POS_MAX, POS_MIN, 32'd3400, 0, 0, 0);
    poke(0, MODE_STOP, 21, 10, 32'd3410, 0, 0, 0);   // just outside the band
    poke(0, MODE_STOP, 20, 10, 32'd3420, 0, 0, 0);   // on the band edge
    poke(1, MODE_GOTO, -5, 5, 32'd3430, 0, 0, 0);    // already arrived
    poke(1, MODE_GOTO, 0, 100, 32'd3440, 0, 0, 1);
    poke(1, MODE_STOP, 0, 100, 32'd3450, 0, 0, 1);   // protection stop during go-to
    poke(1, MODE_OPEN, 0, 0, 32'hffff_ff00, 0, 0, 0);
    poke(1, MODE_CLOSE, 0, 0, 32'hffff_fff0, 0, 0, 0);
    poke(0, MODE_STOP, 0, 0, 32'd1000, 0, 0, 0);     // pause ends across time wrap
  endtask

  task automatic run_random(int n);
    item_t it;
    int    span;
    int    step;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 8) begin
        it.cmd_valid = 1'($urandom);
        it.cmd = 2'($urandom);
        it.position = $urandom;
        it.target_position = $urandom;
        it.now_ms = $urandom;
        it.at_closed_stop = 1'($urandom);
        it.at_open_stop = 1'($urandom);
        it.protect_tripped = 1'($urandom);
      end else begin
        world_ms += ($urandom_range(99) < 3) ? 32'($urandom_range(70000))
                                             : 32'($urandom_range(150));
        it.cmd_valid = ($urandom_range(99) < 10);
        it.cmd = 2'($urandom_range(3));
        if (it.cmd_valid && it.cmd == MODE_GOTO) begin
          span = ($urandom_range(3) == 0) ? 20 : 3000;
          world_tgt = world_pos + int'($urandom_range(2 * span)) - span;
        end
        step = ($urandom_range(9) == 0) ? int'($urandom_range(500)) : int'($urandom_range(40));
        if (world_pos < world_tgt) world_pos += step;
        else world_pos -= step;
        it.position = world_pos;
        it.target_position = world_tgt;
        it.now_ms = world_ms;
        it.at_closed_stop = ($urandom_range(99) < 6);
        it.at_open_stop = ($urandom_range(99) < 6);
        it.protect_tripped = ($urandom_range(99) < 8);
      end
      send_tick(it);
      if ($urandom_range(299) == 0) drain();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    directed_ticks();
    run_random(200);
    drain();
    run_random(100);
    program_regs(8'd255, 10'd0, 16'd0, 1'b1);
    run_random(250);
    program_regs(8'd0, 10'd1023, 16'hffff, 1'b0);
    world_ms = 32'hffff_f000;
    run_random(250);
    program_regs(8'($urandom), 10'($urandom_range(40)), 16'($urandom_range(3000)), 1'b1);
    quiet = 1'b1;
    run_random(200);
    quiet = 1'b0;
    run_random(200);
    drain();
    $display("covered %0d ticks, %0d result checks, four register settings incl. extremes",
             sb.ticks, sb.checked);
    $display("reversal pauses entered: %0d, protection stops: %0d", sb.pauses, sb.stop_events);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
